// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the text parser RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high
`define ITP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is checked during reset as well
`define ITP_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/itp_pkg.sv =====
// ----------------------------------------------------------------------------
// itp_pkg
// Types and constants shared by the integer text parser modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package itp_pkg;

   // Sizing
   localparam int MAX_DIGITS  = 16;
   localparam int VALUE_BITS  = 32;
   localparam int OUT_BITS    = 32;
   localparam int ALPHA_SLOTS = 16;
   localparam int LEN_BITS    = 5;
   localparam int POS_BITS    = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
   localparam int CSR_DATA_BITS = 64;
   localparam int CSR_IDX_BITS  = 2;

   // Register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_ALPHA_LOW  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ALPHA_HIGH = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ALPHA_LEN  = 2'd2;

   // Characters
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_LIMIT = 8'd13;
   localparam logic [7:0] CHAR_HIGH  = 8'd128;

   typedef logic [ALPHA_SLOTS-1:0][7:0] alphabet_type;

   typedef enum logic [1:0] {
      PH_SPACE = 2'd0,
      PH_SIGN  = 2'd1,
      PH_DIGIT = 2'd2,
      PH_DONE  = 2'd3
   } phase_type;

   typedef struct packed {
      logic                hit;
      logic [POS_BITS-1:0] pos;
   } digit_hit_type;

   typedef struct packed {
      logic [OUT_BITS-1:0] value;
      logic                invalid;
   } result_type;

endpackage

// ===== sv/itp_alpha_check.sv =====
// ----------------------------------------------------------------------------
// itp_alpha_check
// Flags a configured digit alphabet that cannot be used for parsing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module itp_alpha_check (
   input  itp_pkg::alphabet_type            alphabet,
   input  logic [itp_pkg::LEN_BITS-1:0]     alpha_len,
   output logic                             alpha_bad
);

   // Check length, byte range, sign characters and duplicates in parallel
   always_comb begin
      logic bad;
      bad = (alpha_len < itp_pkg::LEN_BITS'(2)) ||
            (alpha_len > itp_pkg::LEN_BITS'(itp_pkg::MAX_DIGITS));
      for (int i = 0; i < itp_pkg::ALPHA_SLOTS; i++) begin
         if (itp_pkg::LEN_BITS'(i) < alpha_len) begin
            if ((alphabet[i] <= itp_pkg::CHAR_LIMIT) ||
                (alphabet[i] >= itp_pkg::CHAR_HIGH) ||
                (alphabet[i] == itp_pkg::CHAR_PLUS) ||
                (alphabet[i] == itp_pkg::CHAR_MINUS)) begin
               bad = 1'b1;
            end
            for (int j = i + 1; j < itp_pkg::ALPHA_SLOTS; j++) begin
               if ((itp_pkg::LEN_BITS'(j) < alpha_len) && (alphabet[j] == alphabet[i])) begin
                  bad = 1'b1;
               end
            end
         end
      end
      alpha_bad = bad;
   end

endmodule

// ===== sv/itp_digit_map.sv =====
// ----------------------------------------------------------------------------
// itp_digit_map
// Maps a text byte to its digit position in the configured alphabet.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module itp_digit_map (
   input  itp_pkg::alphabet_type          alphabet,
   input  logic [itp_pkg::LEN_BITS-1:0]   alpha_len,
   input  logic [7:0]                     text_byte,
   output itp_pkg::digit_hit_type         digit
);

   logic [itp_pkg::LEN_BITS-1:0] used_len;

   // Search only the slots in use, capped at the digit limit
   assign used_len = (alpha_len > itp_pkg::LEN_BITS'(itp_pkg::MAX_DIGITS)) ?
                     itp_pkg::LEN_BITS'(itp_pkg::MAX_DIGITS) : alpha_len;

   // Compare all slots at once; scan downward so the lowest match wins
   always_comb begin
      digit.hit = 1'b0;
      digit.pos = '0;
      for (int i = itp_pkg::MAX_DIGITS - 1; i >= 0; i--) begin
         if ((itp_pkg::LEN_BITS'(i) < used_len) && (alphabet[i] == text_byte)) begin
            digit.hit = 1'b1;
            digit.pos = itp_pkg::POS_BITS'(i);
         end
      end
   end

endmodule

// ===== sv/itp_parse_core.sv =====
// ----------------------------------------------------------------------------
// itp_parse_core
// Parse state machine: sign, accumulator and the result of each text.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module itp_parse_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             step_en,
   input  logic [7:0]                       step_byte,
   input  logic                             step_last,
   input  itp_pkg::alphabet_type            alphabet,
   input  logic [itp_pkg::LEN_BITS-1:0]     alpha_len,
   input  logic                             alpha_bad,
   output itp_pkg::result_type              result
);

   itp_pkg::phase_type                 phase_ff, phase_in;
   logic                               neg_ff, neg_in;
   logic [itp_pkg::VALUE_BITS-1:0]     acc_ff, acc_in;
   itp_pkg::digit_hit_type             digit;
   logic                               is_space;
   logic                               is_sign;
   logic [itp_pkg::VALUE_BITS-1:0]     signed_val;
   logic [63:0]                        wide_val;

   itp_digit_map u_digit_map (
      .alphabet  (alphabet),
      .alpha_len (alpha_len),
      .text_byte (step_byte),
      .digit     (digit)
   );

   assign is_space = ((step_byte >= itp_pkg::CHAR_TAB) && (step_byte <= itp_pkg::CHAR_CR)) ||
                     (step_byte == itp_pkg::CHAR_SPACE);
   assign is_sign  = (step_byte == itp_pkg::CHAR_PLUS) || (step_byte == itp_pkg::CHAR_MINUS);

   // Next phase, sign and accumulator for the byte at hand
   always_comb begin
      phase_in = phase_ff;
      neg_in   = neg_ff;
      acc_in   = acc_ff;
      unique case (phase_ff)
         itp_pkg::PH_SPACE,
         itp_pkg::PH_SIGN,
         itp_pkg::PH_DIGIT: begin
            if (step_byte == itp_pkg::CHAR_NUL) begin
               phase_in = itp_pkg::PH_DONE;
            end else if ((phase_ff == itp_pkg::PH_SPACE) && is_space) begin
               phase_in = itp_pkg::PH_SPACE;
            end else if ((phase_ff != itp_pkg::PH_DIGIT) && is_sign) begin
               phase_in = itp_pkg::PH_SIGN;
               if (step_byte == itp_pkg::CHAR_MINUS) begin
                  neg_in = ~neg_ff;
               end
            end else if (digit.hit) begin
               acc_in = itp_pkg::VALUE_BITS'(acc_ff * itp_pkg::VALUE_BITS'(alpha_len)) +
                        itp_pkg::VALUE_BITS'(digit.pos);
               phase_in = itp_pkg::PH_DIGIT;
            end else begin
               phase_in = itp_pkg::PH_DONE;
            end
         end
         itp_pkg::PH_DONE: begin
            phase_in = itp_pkg::PH_DONE;
         end
         default: begin
            phase_in = itp_pkg::PH_DONE;
         end
      endcase
   end

   // Apply sign, wrap, and force zero on a bad alphabet
   assign signed_val     = neg_in ? (itp_pkg::VALUE_BITS'(0) - acc_in) : acc_in;
   assign wide_val       = 64'(signed_val);
   assign result.value   = alpha_bad ? '0 : wide_val[itp_pkg::OUT_BITS-1:0];
   assign result.invalid = alpha_bad;

   // Advance on each processed byte; clear after the last byte of a text
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= itp_pkg::PH_SPACE;
         neg_ff   <= 1'b0;
         acc_ff   <= '0;
      end else if (step_en) begin
         if (step_last) begin
            phase_ff <= itp_pkg::PH_SPACE;
            neg_ff   <= 1'b0;
            acc_ff   <= '0;
         end else begin
            phase_ff <= phase_in;
            neg_ff   <= neg_in;
            acc_ff   <= acc_in;
         end
      end
   end

   `ITP_ASSERT(a_clear_after_last, clock, reset,
      step_en && step_last |=> (phase_ff == itp_pkg::PH_SPACE) && !neg_ff && (acc_ff == '0),
      "parse state not cleared after last byte")
   `ITP_ASSERT(a_done_holds_acc, clock, reset,
      (phase_ff == itp_pkg::PH_DONE) && !(step_en && step_last) |=> $stable(acc_ff),
      "accumulator moved after parsing ended")

endmodule

// ===== sv/integer_text_parser_any_base_top.sv =====
// ----------------------------------------------------------------------------
// integer_text_parser_any_base_top
// Streaming signed integer parser with a configurable digit alphabet.
// ----------------------------------------------------------------------------
// Usage:
//   Text enters one byte per transfer on the req_ channel (valid/ready).
//   req_end_of_text marks the final byte of a text; only that byte yields a
//   result on the rsp_ channel: parsed value plus the bad-alphabet flag.
//   The alphabet (two 64-bit words of digit bytes and a length) is written
//   through the csr_ port while no text is in flight.
// Throughput and pipeline:
//   One byte per cycle, unless a last byte waits for the result slot. A byte
//   sits in the input register while the parse step (parallel alphabet compare
//   and one multiply-add on the accumulator) runs; the result register loads
//   when a last byte leaves it, and the result is valid in the next cycle.
// Reset:
//   Synchronous reset clears the alphabet registers, parse state and both
//   valid flags; the alphabet reads as invalid until configured.
// Stalls:
//   While a result waits on rsp_ready, bytes that are not last keep flowing;
//   a last byte holds in the input register until the result slot frees.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module integer_text_parser_any_base_top (
   input  logic                                   clock,
   input  logic                                   reset,
   // Text input
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [7:0]                             req_text_byte,
   input  logic                                   req_end_of_text,
   // Result output
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [itp_pkg::OUT_BITS-1:0]    rsp_parsed_value,
   output logic                                   rsp_alphabet_invalid,
   // Configuration writes
   input  logic                                   csr_write_enable,
   input  logic [itp_pkg::CSR_IDX_BITS-1:0]       csr_index,
   input  logic [itp_pkg::CSR_DATA_BITS-1:0]      csr_write_data
);

   logic [63:0]                      alpha_low_ff;
   logic [63:0]                      alpha_high_ff;
   logic [itp_pkg::LEN_BITS-1:0]     alpha_len_ff;
   itp_pkg::alphabet_type            alphabet;
   logic                             alpha_bad;

   logic                             s1_valid_ff, s1_valid_in;
   logic [7:0]                       s1_byte_ff;
   logic                             s1_last_ff;
   logic                             s1_fire;
   logic                             req_fire;
   logic                             out_free;

   logic                             rsp_valid_ff, rsp_valid_in;
   logic [itp_pkg::OUT_BITS-1:0]     rsp_value_ff;
   logic                             rsp_invalid_ff;
   itp_pkg::result_type              result;

   // Configuration register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_low_ff  <= '0;
         alpha_high_ff <= '0;
         alpha_len_ff  <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            itp_pkg::CSR_ALPHA_LOW:  alpha_low_ff  <= csr_write_data[63:0];
            itp_pkg::CSR_ALPHA_HIGH: alpha_high_ff <= csr_write_data[63:0];
            itp_pkg::CSR_ALPHA_LEN:  alpha_len_ff  <= csr_write_data[itp_pkg::LEN_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   assign alphabet = {alpha_high_ff, alpha_low_ff};

   itp_alpha_check u_alpha_check (
      .alphabet  (alphabet),
      .alpha_len (alpha_len_ff),
      .alpha_bad (alpha_bad)
   );

   // Handshake: a last byte needs a free result slot, others always go
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_fire   = s1_valid_ff && (!s1_last_ff || out_free);
   assign req_ready = !s1_valid_ff || s1_fire;
   assign req_fire  = req_valid && req_ready;

   assign s1_valid_in  = req_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = (s1_fire && s1_last_ff) ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_byte_ff <= req_text_byte;
         s1_last_ff <= req_end_of_text;
      end
   end

   itp_parse_core u_parse_core (
      .clock     (clock),
      .reset     (reset),
      .step_en   (s1_fire),
      .step_byte (s1_byte_ff),
      .step_last (s1_last_ff),
      .alphabet  (alphabet),
      .alpha_len (alpha_len_ff),
      .alpha_bad (alpha_bad),
      .result    (result)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire && s1_last_ff) begin
         rsp_value_ff   <= result.value;
         rsp_invalid_ff <= result.invalid;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_parsed_value     = rsp_value_ff;
   assign rsp_alphabet_invalid = rsp_invalid_ff;

   `ITP_ASSERT(a_last_gives_result, clock, reset,
      s1_fire && s1_last_ff |=> rsp_valid_ff,
      "last byte processed without a result")
   `ITP_ASSERT(a_no_spurious_result, clock, reset,
      !rsp_valid_ff && !(s1_fire && s1_last_ff) |=> !rsp_valid_ff,
      "result appeared without a last byte")
   `ITP_ASSERT(a_invalid_zero, clock, reset,
      rsp_valid_ff && rsp_invalid_ff |-> (rsp_value_ff == '0),
      "invalid alphabet result is not zero")
   `ITP_ASSERT_ALWAYS(a_last_waits_slot, clock,
      s1_fire && s1_last_ff |-> out_free,
      "last byte processed while result slot busy")

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for integer_text_parser_any_base_top. Text bytes stream
// in over the req_ channel. A scoreboard tracks the alphabet registers and the
// parse state and predicts the value and the bad-alphabet flag of each text.
// The rsp_ channel is checked against that prediction in order. A short
// directed part covers whitespace, signs, wrap-around and early stops. Random
// phases then load fresh alphabets, both legal and broken, and stream
// well-formed and noisy texts with random stalls on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

   localparam logic [itp_pkg::CSR_IDX_BITS-1:0] CSR_UNUSED = 2'd3;
   localparam int PHASE_ITEMS = 170;
   localparam int PHASE_COUNT = 12;

   typedef enum int {
      ALPHA_FULL,
      ALPHA_BINARY,
      ALPHA_ONES,
      ALPHA_EMPTY,
      ALPHA_LEGAL,
      ALPHA_CORRUPT,
      ALPHA_BAD_LENGTH,
      ALPHA_NOISE
   } alpha_kind_type;

   // Predicts parse results from its own copy of the alphabet and parse state
   class parse_scoreboard;
      logic [63:0]          alpha_low;
      logic [63:0]          alpha_high;
      logic [4:0]           alpha_len;
      itp_pkg::phase_type   phase;
      bit                   negative;
      logic [31:0]          acc;
      itp_pkg::result_type  expected_results[$];
      int                   errors;

      function new();
         alpha_low  = '0;
         alpha_high = '0;
         alpha_len  = '0;
         phase      = itp_pkg::PH_SPACE;
         negative   = 1'b0;
         acc        = '0;
         errors     = 0;
      endfunction

      function void set_register(logic [itp_pkg::CSR_IDX_BITS-1:0] idx, logic [63:0] data);
         if (idx == itp_pkg::CSR_ALPHA_LOW) alpha_low = data;
         else if (idx == itp_pkg::CSR_ALPHA_HIGH) alpha_high = data;
         else if (idx == itp_pkg::CSR_ALPHA_LEN) alpha_len = data[4:0];
      endfunction

      function logic [7:0] digit_char(int pos);
         return (pos < 8) ? alpha_low[pos*8 +: 8] : alpha_high[(pos-8)*8 +: 8];
      endfunction

      function int search_limit();
         return (alpha_len > itp_pkg::MAX_DIGITS) ? itp_pkg::MAX_DIGITS : int'(alpha_len);
      endfunction

      function bit alphabet_bad();
         int i, j;
         logic [7:0] c;
         if (alpha_len < 2 || alpha_len > itp_pkg::MAX_DIGITS) return 1'b1;
         for (i = 0; i < alpha_len; i++) begin
            c = digit_char(i);
            if (c <= itp_pkg::CHAR_LIMIT || c >= itp_pkg::CHAR_HIGH ||
                c == itp_pkg::CHAR_PLUS || c == itp_pkg::CHAR_MINUS)
               return 1'b1;
            for (j = i + 1; j < alpha_len; j++)
               if (digit_char(j) == c) return 1'b1;
         end
         return 1'b0;
      endfunction

      // Lowest matching position wins; -1 when the byte is no digit
      function int digit_position(logic [7:0] c);
         int i;
         for (i = 0; i < search_limit(); i++)
            if (digit_char(i) == c) return i;
         return -1;
      endfunction

      function void note_byte(logic [7:0] b, logic last);
         int d;
         itp_pkg::result_type want;
         if (phase != itp_pkg::PH_DONE) begin
            if (b == itp_pkg::CHAR_NUL) begin
               phase = itp_pkg::PH_DONE;
            end else if (phase == itp_pkg::PH_SPACE &&
                         ((b >= itp_pkg::CHAR_TAB && b <= itp_pkg::CHAR_CR) ||
                          b == itp_pkg::CHAR_SPACE)) begin
               // skip leading whitespace
            end else if (phase <= itp_pkg::PH_SIGN &&
                         (b == itp_pkg::CHAR_PLUS || b == itp_pkg::CHAR_MINUS)) begin
               phase = itp_pkg::PH_SIGN;
               if (b == itp_pkg::CHAR_MINUS) negative = !negative;
            end else begin
               d = digit_position(b);
               if (d >= 0) begin
                  acc   = acc * {27'd0, alpha_len} + 32'(d);
                  phase = itp_pkg::PH_DIGIT;
               end else begin
                  phase = itp_pkg::PH_DONE;
               end
            end
         end
         if (last) begin
            want.invalid = alphabet_bad();
            want.value   = want.invalid ? '0 : (negative ? 32'd0 - acc : acc);
            expected_results.push_back(want);
            phase    = itp_pkg::PH_SPACE;
            negative = 1'b0;
            acc      = '0;
         end
      endfunction

      function void check_result(logic [31:0] value, logic invalid);
         itp_pkg::result_type want;
         if (expected_results.size() == 0) begin
            errors++;
            $display("%0t: result with none expected: value %0d flag %0b",
                     $time, $signed(value), invalid);
            return;
         end
         want = expected_results.pop_front();
         if (value !== want.value) begin
            errors++;
            $display("%0t: parsed_value expected %0d actual %0d",
                     $time, $signed(want.value), $signed(value));
         end
         if (invalid !== want.invalid) begin
            errors++;
            $display("%0t: alphabet_invalid expected %0b actual %0b",
                     $time, want.invalid, invalid);
         end
      endfunction

      function int waiting();
         return expected_results.size();
      endfunction
   endclass

   logic                                  clock;
   logic                                  reset;
   logic                                  req_valid;
   logic                                  req_ready;
   logic [7:0]                            req_text_byte;
   logic                                  req_end_of_text;
   logic                                  rsp_valid;
   logic                                  rsp_ready;
   logic signed [itp_pkg::OUT_BITS-1:0]   rsp_parsed_value;
   logic                                  rsp_alphabet_invalid;
   logic                                  csr_write_enable;
   logic [itp_pkg::CSR_IDX_BITS-1:0]      csr_index;
   logic [itp_pkg::CSR_DATA_BITS-1:0]     csr_write_data;

   parse_scoreboard sb;
   logic [7:0]      text_q[$];
   logic [7:0]      alpha_chars[16];
   int              items_sent;
   bit              sender_steady;
   bit              receiver_steady;

   integer_text_parser_any_base_top dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_text_byte        (req_text_byte),
      .req_end_of_text      (req_end_of_text),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_parsed_value     (rsp_parsed_value),
      .rsp_alphabet_invalid (rsp_alphabet_invalid),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Abort a hung run
   initial begin
      #4_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   // Mostly short gaps, a few long ones
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Result side: random stalls unless a phase asks for a steady receiver
   initial begin
      int hold;
      hold      = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (receiver_steady) begin
            rsp_ready <= 1'b1;
         end else if (hold > 0) begin
            hold--;
         end else if ($urandom_range(0, 9) < 7) begin
            rsp_ready <= 1'b1;
            hold = $urandom_range(0, 7);
         end else begin
            rsp_ready <= 1'b0;
            hold = idle_length();
         end
      end
   end

   // Check every result transfer
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(rsp_parsed_value, rsp_alphabet_invalid);
   end

   // Present one byte and hold it until the transfer; valid stays high after
   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      gap = sender_steady ? 0 : idle_length();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_text_byte   <= b;
      req_end_of_text <= last;
      forever begin
         @(posedge clock);
         if (req_ready) break;
      end
      sb.note_byte(b, last);
      items_sent++;
   endtask

   task automatic send_text();
      int i;
      for (i = 0; i < text_q.size(); i++)
         send_byte(text_q[i], i == text_q.size() - 1);
      text_q.delete();
   endtask

   // Drop valid, then hold until every expected result is back
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.waiting() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [itp_pkg::CSR_IDX_BITS-1:0] idx,
                            input logic [63:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      sb.set_register(idx, data);
   endtask

   task automatic load_alphabet(input logic [63:0] low, input logic [63:0] high,
                                input logic [4:0] len);
      write_csr(itp_pkg::CSR_ALPHA_LOW, low);
      write_csr(itp_pkg::CSR_ALPHA_HIGH, high);
      write_csr(itp_pkg::CSR_ALPHA_LEN, {59'd0, len});
   endtask

   // Fill the first n slots with distinct legal digits, the rest with junk
   task automatic build_legal(input int n);
      int i, j;
      logic [7:0] c;
      bit clash;
      for (i = 0; i < 16; i++) alpha_chars[i] = 8'($urandom_range(0, 255));
      for (i = 0; i < n; i++) begin
         clash = 1'b1;
         while (clash) begin
            c     = 8'($urandom_range(14, 127));
            clash = (c == itp_pkg::CHAR_PLUS || c == itp_pkg::CHAR_MINUS);
            for (j = 0; j < i; j++)
               if (alpha_chars[j] == c) clash = 1'b1;
         end
         alpha_chars[i] = c;
      end
   endtask

   task automatic pick_alphabet(input alpha_kind_type kind);
      int n, i, j, k;
      logic [63:0] low, high;
      case (kind)
         ALPHA_FULL: begin
            n = 16;
            build_legal(n);
         end
         ALPHA_BINARY: begin
            n = 2;
            build_legal(n);
         end
         ALPHA_ONES: begin
            n = 31;
            for (i = 0; i < 16; i++) alpha_chars[i] = 8'hFF;
         end
         ALPHA_EMPTY: begin
            n = 0;
            for (i = 0; i < 16; i++) alpha_chars[i] = 8'h00;
         end
         ALPHA_CORRUPT: begin
            // legal set with one offending byte
            n = $urandom_range(2, 16);
            build_legal(n);
            i = $urandom_range(0, n - 1);
            k = $urandom_range(0, 3);
            if (k == 0) begin
               alpha_chars[i] = 8'($urandom_range(0, 13));
            end else if (k == 1) begin
               alpha_chars[i] = 8'($urandom_range(128, 255));
            end else if (k == 2) begin
               alpha_chars[i] = $urandom_range(0, 1) ? itp_pkg::CHAR_PLUS :
                                                       itp_pkg::CHAR_MINUS;
            end else begin
               j = $urandom_range(0, n - 1);
               if (j == i) j = (i + 1) % n;
               alpha_chars[i] = alpha_chars[j];
            end
         end
         ALPHA_BAD_LENGTH: begin
            n = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(17, 31);
            build_legal(16);
         end
         ALPHA_NOISE: begin
            n = $urandom_range(0, 31);
            for (i = 0; i < 16; i++) alpha_chars[i] = 8'($urandom_range(0, 255));
         end
         default: begin
            n = $urandom_range(2, 16);
            build_legal(n);
         end
      endcase
      for (i = 0; i < 8; i++) begin
         low[i*8 +: 8]  = alpha_chars[i];
         high[i*8 +: 8] = alpha_chars[i + 8];
      end
      load_alphabet(low, high, n[4:0]);
      // the spare index must leave the alphabet alone
      if ($urandom_range(0, 1)) write_csr(CSR_UNUSED, {$urandom, $urandom});
   endtask

   task automatic push_whitespace();
      int k;
      k = $urandom_range(0, 5);
      text_q.push_back((k == 5) ? itp_pkg::CHAR_SPACE : itp_pkg::CHAR_TAB + 8'(k));
   endtask

   // Mostly well-formed texts with random content, some noise and early stops
   task automatic send_random_text();
      int n, i, r, limit, pos;
      if ($urandom_range(0, 99) < 15) begin
         n = $urandom_range(1, 8);
         for (i = 0; i < n; i++) text_q.push_back(8'($urandom_range(0, 255)));
      end else begin
         n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
         for (i = 0; i < n; i++) push_whitespace();
         n = ($urandom_range(0, 4) == 0) ? $urandom_range(2, 4) : $urandom_range(0, 1);
         for (i = 0; i < n; i++)
            text_q.push_back($urandom_range(0, 1) ? itp_pkg::CHAR_MINUS : itp_pkg::CHAR_PLUS);
         if ($urandom_range(0, 9) == 0) push_whitespace();
         limit = sb.search_limit();
         n = ($urandom_range(0, 6) == 0) ? $urandom_range(10, 14) : $urandom_range(0, 9);
         if (limit > 0) begin
            for (i = 0; i < n; i++) begin
               r = $urandom_range(0, 9);
               pos = (r == 0) ? limit - 1 : (r == 1) ? 0 : $urandom_range(0, limit - 1);
               text_q.push_back(sb.digit_char(pos));
            end
         end
         r = $urandom_range(0, 3);
         if (r == 1) text_q.push_back(itp_pkg::CHAR_NUL);
         else if (r == 2) text_q.push_back(8'($urandom_range(0, 255)));
         else if (r == 3)
            text_q.push_back($urandom_range(0, 1) ? itp_pkg::CHAR_MINUS : itp_pkg::CHAR_PLUS);
         if (r != 0) begin
            n = $urandom_range(0, 3);
            for (i = 0; i < n; i++) text_q.push_back(8'($urandom_range(0, 255)));
         end
      end
      if (text_q.size() == 0) text_q.push_back(8'($urandom_range(0, 255)));
      send_text();
   endtask

   initial begin
      int phase_idx, phase_start, r;
      alpha_kind_type kind;
      sb               = new();
      items_sent       = 0;
      sender_steady    = 1'b0;
      receiver_steady  = 1'b0;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_text_byte    = '0;
      req_end_of_text  = 1'b0;
      csr_write_enable = 1'b0;
      csr_index        = itp_pkg::CSR_ALPHA_LOW;
      csr_write_data   = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // alphabet after reset is empty: the flag must be raised
      text_q.push_back("7");
      send_text();
      settle();

      // decimal alphabet "0123456789"
      load_alphabet(64'h3736353433323130, 64'h0000000000003938, 5'd10);
      text_q.push_back(itp_pkg::CHAR_TAB);
      text_q.push_back(itp_pkg::CHAR_SPACE);
      text_q.push_back(itp_pkg::CHAR_MINUS);
      text_q.push_back("1");
      text_q.push_back("2");
      send_text();
      // whitespace after a sign stops the parse, the trailing digit is ignored
      text_q.push_back(itp_pkg::CHAR_MINUS);
      text_q.push_back(itp_pkg::CHAR_SPACE);
      text_q.push_back("5");
      send_text();
      text_q.push_back(itp_pkg::CHAR_NUL);
      send_text();
      text_q.push_back(8'hFF);
      send_text();
      settle();

      // base 16 with the lowest and highest legal bytes and space as digit one
      load_alphabet(64'h353433323130200E, 64'h7F67666564636261, 5'd16);
      text_q.push_back(itp_pkg::CHAR_CR);
      text_q.push_back(itp_pkg::CHAR_SPACE);
      text_q.push_back(itp_pkg::CHAR_MINUS);
      text_q.push_back(itp_pkg::CHAR_SPACE);
      repeat (8) text_q.push_back(8'h7F);
      send_text();
      settle();

      // random phases, each with a fresh alphabet
      for (phase_idx = 0; phase_idx < PHASE_COUNT; phase_idx++) begin
         if (phase_idx < 4) begin
            kind = alpha_kind_type'(phase_idx);
         end else begin
            r = $urandom_range(0, 9);
            kind = (r < 5) ? ALPHA_LEGAL : (r < 7) ? ALPHA_CORRUPT :
                   (r == 7) ? ALPHA_BAD_LENGTH : (r == 8) ? ALPHA_NOISE : ALPHA_FULL;
         end
         pick_alphabet(kind);
         sender_steady   = ($urandom_range(0, 4) == 0);
         receiver_steady = ($urandom_range(0, 4) == 0);
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS) begin
            send_random_text();
            if ($urandom_range(0, 49) == 0) settle();
         end
         settle();
      end

      repeat (8) @(posedge clock);
      if (sb.errors == 0 && sb.waiting() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
